### hdl/source_id_set_table_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef SOURCE_ID_SET_TABLE_UNIT_DEFINES_SVH
`define SOURCE_ID_SET_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SIST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked while out of reset.
`define SIST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### hdl/sist_pkg.sv
package sist_pkg;

  // Table geometry
  localparam int MaxSources = 255;
  localparam int IdxW       = 8;
  localparam int IdW        = 32;
  localparam int LenW       = 9;
  localparam int ReasonW    = 8;

  // Request kinds; the unused code behaves as a find
  typedef enum logic [1:0] {
    REQ_FIND   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_DUP  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_DONE
  } state_e;

  // Table memory access, sequencer to RAM
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [IdW-1:0]  wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

  // Packet length in words minus one. With a reason the size is
  // 4 + 4*count + reason rounded up past the next multiple of four,
  // which reduces to count + 1 + reason/4.
  function automatic logic [LenW-1:0] length_word_of(logic [IdxW-1:0]    count,
                                                     logic [ReasonW-1:0] reason);
    if (reason == '0) begin
      return LenW'(count);
    end
    return LenW'(count) + LenW'(1) + LenW'(reason[ReasonW-1:2]);
  endfunction

endpackage

### hdl/sist_req_if.sv
interface sist_req_if import sist_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      req_type;
  logic [IdW-1:0]  src_id;

  modport source (output valid, req_type, src_id, input ready);
  modport sink   (input valid, req_type, src_id, output ready);
endinterface

### hdl/sist_rsp_if.sv
interface sist_rsp_if import sist_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic             found;
  logic [IdxW-1:0]  index;
  logic [IdxW-1:0]  entry_count;
  logic [LenW-1:0]  length_word;

  modport source (output valid, status, found, index, entry_count, length_word,
                  input ready);
  modport sink   (input valid, status, found, index, entry_count, length_word,
                  output ready);
endinterface

### hdl/source_id_set_table_unit.sv
// Source identifier set table.
// Requests arrive on req_i (req_type, src_id) with a valid/ready handshake;
// one result per request leaves on rsp_o (status, found, index, entry_count,
// length_word). req_type 0 finds, 1 adds, 2 removes; 3 behaves as a find.
// cfg_we_i/cfg_wdata_i write the reason length used for length_word.
// Identifiers live in a 255 x 32 single-write, registered-read RAM.
// The scan reads one entry per cycle and stops at a match or at the count;
// a removal then shifts every later entry down one place. One request is
// worked on at a time.
// req_i.ready is high only while no request is in flight. A finished result
// sits in the output register; if rsp_o is stalled, the next request is still
// accepted and runs, and its result waits until the register is taken.
// Reset empties the table (count zero) and clears the reason length; the
// RAM itself is not cleared, as entries at or above the count are never read.
module source_id_set_table_unit import sist_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ReasonW-1:0]  cfg_wdata_i,
  sist_req_if.sink            req_i,
  sist_rsp_if.source          rsp_o
);

  mem_req_t       mem_req;
  logic [IdW-1:0] mem_rdata;

  // Request sequencer
  sist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Identifier store
  sist_ram #(
    .Width (IdW),
    .Depth (MaxSources),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

### hdl/sist_ram.sv
module sist_ram #(
  parameter int Width = 32,
  parameter int Depth = 255,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sist_ctrl.sv
module sist_ctrl import sist_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ReasonW-1:0]  cfg_wdata_i,
  sist_req_if.sink            req_i,
  sist_rsp_if.source          rsp_o,
  output mem_req_t            mem_o,
  input  logic [IdW-1:0]      mem_rdata_i
);

  state_e            state_q, state_d;
  logic [1:0]        kind_q, kind_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [IdxW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;       // next address to read
  logic              cmp_v_q, cmp_v_d;   // read data valid this cycle
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   match_q, match_d;
  status_e           status_q, status_d;
  logic [ReasonW-1:0] reason_q;

  logic              rsp_valid_q, rsp_valid_d;
  logic              load_rsp;
  logic [1:0]        rsp_status_q;
  logic              rsp_found_q;
  logic [IdxW-1:0]   rsp_index_q;
  logic [IdxW-1:0]   rsp_count_q;
  logic [LenW-1:0]   rsp_len_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cmp_v_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
      reason_q    <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmp_v_q     <= cmp_v_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        reason_q <= cfg_wdata_i;
      end
    end
  end

  // Working registers of the request in flight
  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    id_q      <= id_d;
    ptr_q     <= ptr_d;
    cmp_idx_q <= cmp_idx_d;
    found_q   <= found_d;
    match_q   <= match_d;
    status_q  <= status_d;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      rsp_status_q <= status_q;
      rsp_found_q  <= found_q;
      rsp_index_q  <= match_q;
      rsp_count_q  <= count_q;
      rsp_len_q    <= length_word_of(count_q, reason_q);
    end
  end

  // Sequencer: scan for a match, then add or shift down on removal.
  // Reads are pipelined: address issued one cycle, data compared the next.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    id_d        = id_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    match_d     = match_q;
    status_d    = status_q;
    mem_o       = '0;
    req_i.ready = 1'b0;
    load_rsp    = 1'b0;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          kind_d   = req_i.req_type;
          id_d     = req_i.src_id;
          ptr_d    = '0;
          found_d  = 1'b0;
          match_d  = '0;
          status_d = STATUS_OK;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_v_q && (mem_rdata_i == id_q)) begin
          found_d = 1'b1;
          match_d = cmp_idx_q;
          state_d = ST_DECIDE;
        end else if (ptr_q < count_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q;
          cmp_v_d     = 1'b1;
          cmp_idx_d   = ptr_q;
          ptr_d       = ptr_q + IdxW'(1);
        end else if (!cmp_v_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_DONE;
        case (kind_q)
          REQ_ADD: begin
            if (count_q == IdxW'(MaxSources)) begin
              status_d = STATUS_FULL;
            end else if (found_q) begin
              status_d = STATUS_DUP;
            end else begin
              mem_o.we    = 1'b1;
              mem_o.waddr = count_q;
              mem_o.wdata = id_q;
              count_d     = count_q + IdxW'(1);
            end
          end
          REQ_REMOVE: begin
            if (found_q) begin
              ptr_d   = match_q + IdxW'(1);
              state_d = ST_SHIFT;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SHIFT: begin
        // Entry read last cycle moves down one place
        if (cmp_v_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = cmp_idx_q - IdxW'(1);
          mem_o.wdata = mem_rdata_i;
        end
        if (ptr_q < count_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q;
          cmp_v_d     = 1'b1;
          cmp_idx_d   = ptr_q;
          ptr_d       = ptr_q + IdxW'(1);
        end else if (!cmp_v_q) begin
          count_d = count_q - IdxW'(1);
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_rsp    = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found       = rsp_found_q;
  assign rsp_o.index       = rsp_index_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.length_word = rsp_len_q;

endmodule

### hdl/sist_checker.sv
`include "source_id_set_table_unit_defines.svh"

module sist_checker import sist_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic [1:0]      rsp_status_i,
  input logic            rsp_found_i,
  input logic [IdxW-1:0] rsp_index_i,
  input logic [IdxW-1:0] rsp_count_i,
  input logic [LenW-1:0] rsp_len_i
);

  // Stalled result holds
  `SIST_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i,
                    rsp_valid_i && $stable({rsp_status_i, rsp_found_i, rsp_index_i, rsp_count_i, rsp_len_i}))

  // One request in flight: ready drops after an accept
  `SIST_ASSERT_NEXT(a_one_in_flight, req_valid_i && req_ready_i, !req_ready_i)

  // A miss reports index zero
  `SIST_ASSERT_NOW(a_miss_index, rsp_valid_i && !rsp_found_i, rsp_index_i == '0)

  // A duplicate refusal implies the identifier was found
  `SIST_ASSERT_NOW(a_dup_found, rsp_valid_i && (rsp_status_i == STATUS_DUP), rsp_found_i)

endmodule

bind source_id_set_table_unit sist_checker u_sist_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_found_i  (rsp_o.found),
  .rsp_index_i  (rsp_o.index),
  .rsp_count_i  (rsp_o.entry_count),
  .rsp_len_i    (rsp_o.length_word)
);
